// ----- rtl/rfd_pkg.sv -----
`default_nettype none

package rfd_pkg;

    typedef logic [7:0] t_byte;

    // Most characters one received word can produce
    localparam int NUM_CHARS = 4;
    localparam int NUM_W     = 3;
    localparam int LEFT_W    = 4;

    // Binary controller frame: length, tags and framing characters
    localparam logic [LEFT_W-1:0] BINARY_LEN = 4'd14;
    localparam t_byte CTRL_TAG_A = 8'h14;
    localparam t_byte CTRL_TAG_B = 8'h0D;
    localparam t_byte CHR_OPEN   = 8'h3C;
    localparam t_byte CHR_X      = 8'h58;
    localparam t_byte CHR_CLOSE  = 8'h3E;

    // Register map
    localparam int    ADDR_W       = 3;
    localparam int    DATA_W       = 32;
    localparam logic  REG_START    = 1'b0;
    localparam logic  REG_END      = 1'b1;
    localparam t_byte START_RESET  = 8'd60;
    localparam t_byte END_RESET    = 8'd62;

    // Frame state that does not depend on the text limit
    typedef struct packed {
        logic              start_pending;
        logic              text_open;
        logic [LEFT_W-1:0] binary_left;
    } t_ctl;

    // Upper-case ASCII hex digit of a nibble
    function automatic t_byte hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'h0, nib};
        end else begin
            return 8'h37 + {4'h0, nib};
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/radio_frame_deframer_hex.sv -----
`default_nettype none

// Radio byte deframer: takes one received byte per word and emits frame characters, one
// per output word. A text frame passes its first TEXT_LIMIT-1 bytes and its end marker;
// a binary controller frame (start marker followed by 0x14 or 0x0D) comes out as "<X",
// two upper-case hex digits per byte and ">". Each accepted byte goes into an input
// register, is decoded combinationally into a result register of up to four characters,
// and those drain one per cycle while the output is not stalled. A byte that yields no
// character leaves the result register empty; one that yields n characters holds the
// input until the last of them leaves, so the single output port draining the result
// register sets the sustained byte rate. The next byte is taken in the same cycle as the
// last character of the previous one leaves. Markers are set over the APB port (start at
// 0x0, end at 0x4) and should be changed only while the block is idle.
module radio_frame_deframer_hex #(
    parameter int TEXT_LIMIT = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // received bytes
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rfd_pkg::t_byte                i_in_byte,
    // frame characters
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rfd_pkg::t_byte                o_out_byte,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfd_pkg::ADDR_W-1:0]    paddr,
    input  logic [rfd_pkg::DATA_W-1:0]    pwdata,
    output logic [rfd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import rfd_pkg::*;

    localparam int CNT_W = $clog2(TEXT_LIMIT);

    // configuration registers
    t_byte r_start_marker;
    t_byte r_end_marker;

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // frame state
    t_ctl             r_ctl;
    logic [CNT_W-1:0] r_text_count;

    // result register
    t_byte [NUM_CHARS-1:0] r_buf;
    logic  [NUM_W-1:0]     r_buf_cnt;

    t_ctl                  n_ctl;
    logic [CNT_W-1:0]      n_text_count;
    t_byte [NUM_CHARS-1:0] n_chars;
    logic  [NUM_W-1:0]     n_num;

    logic w_pop;
    logic w_free;
    logic w_take;
    logic w_cfg_wr;

    rfd_step #(
        .TEXT_LIMIT (TEXT_LIMIT),
        .CNT_W      (CNT_W)
    ) u_step (
        .i_byte         (r_in_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .i_ctl          (r_ctl),
        .i_text_count   (r_text_count),
        .o_ctl          (n_ctl),
        .o_text_count   (n_text_count),
        .o_chars        (n_chars),
        .o_num          (n_num)
    );

    // Handshake: the result register frees up when its last character leaves
    assign w_pop       = (r_buf_cnt != '0) && !i_out_stall;
    assign w_free      = (r_buf_cnt == '0) || ((r_buf_cnt == NUM_W'(1)) && w_pop);
    assign w_take      = r_in_valid && w_free;
    assign o_in_stall  = r_in_valid && !w_free;
    assign o_out_valid = (r_buf_cnt != '0);
    assign o_out_byte  = r_buf[0];

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_END) ? {{(DATA_W-8){1'b0}}, r_end_marker}
                                            : {{(DATA_W-8){1'b0}}, r_start_marker};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_RESET;
            r_end_marker   <= END_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_START) begin
                r_start_marker <= pwdata[7:0];
            end else begin
                r_end_marker <= pwdata[7:0];
            end
        end
    end

    // Capture a received word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Advance frame state when a word is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl        <= '0;
            r_text_count <= '0;
        end else if (w_take) begin
            r_ctl        <= n_ctl;
            r_text_count <= n_text_count;
        end
    end

    // Load decoded characters, or shift out one per delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_cnt <= '0;
        end else if (w_take) begin
            r_buf_cnt <= n_num;
        end else if (w_pop) begin
            r_buf_cnt <= r_buf_cnt - NUM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_buf <= n_chars;
        end else if (w_pop) begin
            for (int i = 0; i < NUM_CHARS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rfd_step.sv -----
`default_nettype none

module rfd_step #(
    parameter int TEXT_LIMIT = 100,
    parameter int CNT_W      = 7
) (
    input  rfd_pkg::t_byte                           i_byte,
    input  rfd_pkg::t_byte                           i_start_marker,
    input  rfd_pkg::t_byte                           i_end_marker,
    input  rfd_pkg::t_ctl                            i_ctl,
    input  logic [CNT_W-1:0]                         i_text_count,
    output rfd_pkg::t_ctl                            o_ctl,
    output logic [CNT_W-1:0]                         o_text_count,
    output rfd_pkg::t_byte [rfd_pkg::NUM_CHARS-1:0]  o_chars,
    output logic [rfd_pkg::NUM_W-1:0]                o_num
);
    import rfd_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TEXT_LIMIT - 1);

    logic is_tag;
    logic opened_binary;

    assign is_tag = (i_byte == CTRL_TAG_A) || (i_byte == CTRL_TAG_B);

    // Work out the characters and next frame state for one word
    always_comb begin
        o_ctl         = i_ctl;
        o_text_count  = i_text_count;
        o_chars       = '0;
        o_num         = '0;
        opened_binary = 1'b0;

        if (i_ctl.binary_left != '0) begin
            if (i_ctl.binary_left == LEFT_W'(1)) begin
                // skip the word after the frame
                if (BINARY_LEN == LEFT_W'(1)) begin
                    o_chars[0] = CHR_CLOSE;
                    o_num      = NUM_W'(1);
                end
                o_ctl.binary_left = '0;
            end else begin
                o_chars[0]        = hex_digit(i_byte[7:4]);
                o_chars[1]        = hex_digit(i_byte[3:0]);
                o_num             = NUM_W'(2);
                o_ctl.binary_left = i_ctl.binary_left - LEFT_W'(1);
                if (i_ctl.binary_left == LEFT_W'(2)) begin
                    o_chars[2] = CHR_CLOSE;
                    o_num      = NUM_W'(3);
                end
            end
        end else begin
            // resolve a held start marker
            if (i_ctl.start_pending) begin
                o_ctl.start_pending = 1'b0;
                if (is_tag) begin
                    o_chars[0]        = CHR_OPEN;
                    o_chars[1]        = CHR_X;
                    o_chars[2]        = hex_digit(i_byte[7:4]);
                    o_chars[3]        = hex_digit(i_byte[3:0]);
                    o_num             = NUM_W'(4);
                    o_ctl.binary_left = BINARY_LEN;
                    opened_binary     = 1'b1;
                end else begin
                    o_chars[0]      = i_start_marker;
                    o_num           = NUM_W'(1);
                    o_ctl.text_open = (i_start_marker != i_end_marker);
                    o_text_count    = CNT_W'(1);
                end
            end

            if (!opened_binary) begin
                if (i_byte == i_start_marker) begin
                    // hold the marker, abort any open text frame
                    o_ctl.start_pending = 1'b1;
                    o_ctl.text_open     = 1'b0;
                end else if (o_ctl.text_open) begin
                    if (i_byte == i_end_marker) begin
                        o_chars[o_num[1:0]] = i_byte;
                        o_num               = o_num + NUM_W'(1);
                        o_ctl.text_open     = 1'b0;
                    end else if (o_text_count < CNT_MAX) begin
                        o_chars[o_num[1:0]] = i_byte;
                        o_num               = o_num + NUM_W'(1);
                        o_text_count        = o_text_count + CNT_W'(1);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rfd_check.sv -----
`default_nettype none

module rfd_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input rfd_pkg::t_byte              o_out_byte,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [rfd_pkg::ADDR_W-1:0]  paddr,
    input logic [rfd_pkg::DATA_W-1:0]  pwdata,
    input logic [rfd_pkg::DATA_W-1:0]  prdata,
    input logic                        pready
);
    import rfd_pkg::*;

    // A stalled character holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("stalled output word changed");

    // Reset drops any pending character
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A marker written reads back at the same address
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) |=>
        ((paddr[2] != $past(paddr[2])) || (prdata[7:0] == $past(pwdata[7:0]))))
        else $error("marker register readback mismatch");

    // Markers are 8 bits, upper read bits stay zero
    a_read_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && (prdata[DATA_W-1:8] == '0))
        else $error("register read has upper bits set or not ready");

endmodule

bind radio_frame_deframer_hex rfd_check u_rfd_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

`default_nettype wire

// ----- tb/tb_radio_frame_deframer_hex.sv -----
`timescale 1ns / 100ps

module tb_radio_frame_deframer_hex;
    import rfd_pkg::*;

    localparam int TEXT_LIMIT    = 100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [ADDR_W-1:0] ADDR_START = {REG_START, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_END   = {REG_END, 2'b00};

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } t_stall_mode;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_byte               i_in_byte   = '0;
    logic                i_out_stall = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_byte               o_out_byte;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    radio_frame_deframer_hex #(
        .TEXT_LIMIT(TEXT_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // Deframer model state and marker copies
    t_byte       mark_start  = START_RESET;
    t_byte       mark_end    = END_RESET;
    logic        start_held  = 1'b0;
    logic        text_active = 1'b0;
    logic [6:0]  text_len    = '0;
    logic [3:0]  bin_left    = '0;

    t_byte       expected_chars[$];
    t_byte       byte_backlog[$];
    int          bytes_queued   = 0;
    int          bytes_taken    = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    logic        word_taken     = 1'b0;
    t_byte       want_char;

    // Sender burst shaping
    int          burst_left = 0;
    int          gap_left   = 0;

    // Receiver stall shaping
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    logic [7:0]  stall_pat  = 8'b1011_0010;
    logic        hold_start = 1'b0;
    logic        hold_done  = 1'b0;
    int          hold_left  = 0;

    function automatic t_byte nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return t_byte'("0") + t_byte'(nib);
        end
        return t_byte'("A") + t_byte'(nib) - 8'd10;
    endfunction

    // Advance the deframer model by one received byte and queue its characters
    function automatic void predict_chars(input t_byte b);
        if (bin_left != 4'd0) begin
            if (bin_left == 4'd1) begin
                // trailing byte after a binary frame is skipped unseen
                if (BINARY_LEN == 4'd1) begin
                    expected_chars.push_back(CHR_CLOSE);
                end
                bin_left = 4'd0;
                return;
            end
            expected_chars.push_back(nibble_char(b[7:4]));
            expected_chars.push_back(nibble_char(b[3:0]));
            bin_left = bin_left - 4'd1;
            if (bin_left == 4'd1) begin
                expected_chars.push_back(CHR_CLOSE);
            end
            return;
        end
        if (start_held) begin
            start_held = 1'b0;
            if (b == CTRL_TAG_A || b == CTRL_TAG_B) begin
                expected_chars.push_back(CHR_OPEN);
                expected_chars.push_back(CHR_X);
                expected_chars.push_back(nibble_char(b[7:4]));
                expected_chars.push_back(nibble_char(b[3:0]));
                bin_left = BINARY_LEN;
                return;
            end
            expected_chars.push_back(mark_start);
            text_active = (mark_start != mark_end);
            text_len = 7'd1;
        end
        if (b == mark_start) begin
            start_held = 1'b1;
            text_active = 1'b0;
            return;
        end
        if (text_active) begin
            if (b == mark_end) begin
                expected_chars.push_back(b);
                text_active = 1'b0;
            end else if (text_len < 7'(TEXT_LIMIT - 1)) begin
                expected_chars.push_back(b);
                text_len = text_len + 7'd1;
            end
        end
    endfunction

    // Accept input words into the model, then check output words
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_chars(i_in_byte);
                bytes_taken = bytes_taken + 1;
                word_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: out_byte expected none, actual %h", $time, o_out_byte);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want_char = expected_chars.pop_front();
                    if (o_out_byte !== want_char) begin
                        $display("%0t: out_byte expected %h, actual %h",
                                 $time, want_char, o_out_byte);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
    end

    // Feed words from the backlog in bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_byte <= byte_backlog.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the output on a changing pattern, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_start && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE: begin
                    i_out_stall <= 1'b0;
                end
                STALL_LIGHT: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_HEAVY: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_out_stall <= stall_pat[0];
                    stall_pat <= {stall_pat[0], stall_pat[7:1]};
                end
            endcase
        end
    end

    task automatic push_byte(input t_byte b);
        byte_backlog.push_back(b);
        bytes_queued = bytes_queued + 1;
    endtask

    // Text frame: start marker, a non-tag first byte, content, optional end marker
    task automatic push_text(input int len, input bit closed);
        t_byte b;
        push_byte(mark_start);
        do begin
            b = t_byte'($urandom_range(0, 255));
        end while (b == mark_start || b == mark_end || b == CTRL_TAG_A || b == CTRL_TAG_B);
        push_byte(b);
        for (int i = 1; i < len; i++) begin
            do begin
                b = t_byte'($urandom_range(0, 255));
            end while (b == mark_start || b == mark_end);
            push_byte(b);
        end
        if (closed) begin
            push_byte(mark_end);
        end
    endtask

    // Binary frame: start marker, tag, data bytes often carrying marker values, skip byte
    task automatic push_binary();
        t_byte b;
        push_byte(mark_start);
        push_byte($urandom_range(0, 1) ? CTRL_TAG_A : CTRL_TAG_B);
        for (int i = 1; i < int'(BINARY_LEN); i++) begin
            case ($urandom_range(0, 9))
                0:       b = mark_start;
                1:       b = mark_end;
                2:       b = CTRL_TAG_A;
                default: b = t_byte'($urandom_range(0, 255));
            endcase
            push_byte(b);
        end
        push_byte($urandom_range(0, 1) ? mark_start : t_byte'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed frames, with noise and aborted text mixed in
    task automatic push_random(input int n_bytes);
        int goal;
        int pick;
        goal = bytes_queued + n_bytes;
        while (bytes_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                push_text(($urandom_range(0, 29) == 0) ? $urandom_range(100, 130)
                                                       : $urandom_range(1, 12), 1'b1);
            end else if (pick < 70) begin
                push_binary();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3)) push_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                push_text($urandom_range(1, 6), 1'b0);
            end
        end
    endtask

    // Hold until every byte is taken and every character has come out
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (bytes_taken != bytes_queued || expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check(input logic [ADDR_W-1:0] addr, input t_byte want);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {{(DATA_W - 8){1'b0}}, want}) begin
            $display("%0t: register %0d expected %h, actual %h",
                     $time, addr, {{(DATA_W - 8){1'b0}}, want}, prdata);
            mismatch_count = mismatch_count + 1;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both markers with junk in the unused upper bits, then read them back
    task automatic set_markers(input t_byte s, input t_byte e);
        apb_write(ADDR_START, {24'($urandom_range(0, 32'hFF_FFFF)), s});
        apb_write(ADDR_END, {24'($urandom_range(0, 32'hFF_FFFF)), e});
        mark_start = s;
        mark_end = e;
        apb_check(ADDR_START, s);
        apb_check(ADDR_END, e);
    endtask

    task automatic run_phase(input t_byte s, input t_byte e, input int n_bytes);
        set_markers(s, e);
        @(posedge i_clk);
        push_random(n_bytes);
        wait_idle();
    endtask

    initial begin
        t_byte directed[$];
        directed = '{8'h3E, 8'h00,
                     CHR_OPEN, 8'h41, CHR_OPEN,
                     CTRL_TAG_B, 8'h00, 8'hFF, 8'h3C, 8'h3E, 8'h14, 8'h0D, 8'hA5,
                     8'h5A, 8'h12, 8'h34, 8'h9B, 8'hCD, 8'hEF, CHR_OPEN,
                     CHR_OPEN, CHR_OPEN, 8'h42, CHR_CLOSE};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset markers: check them, then edge cases by hand
        apb_check(ADDR_START, START_RESET);
        apb_check(ADDR_END, END_RESET);
        @(posedge i_clk);
        foreach (directed[i]) push_byte(directed[i]);
        wait_idle();

        // Default markers with one text frame long enough to saturate
        @(posedge i_clk);
        push_text(110, 1'b1);
        push_random(15);
        wait_idle();

        run_phase(8'h00, 8'hFF, 30);
        run_phase(8'hFF, 8'h00, 30);
        run_phase(8'h41, 8'h41, 25);
        run_phase(CTRL_TAG_A, CTRL_TAG_B, 25);

        // Back to defaults while the receiver holds off so the input backs up
        set_markers(START_RESET, END_RESET);
        @(posedge i_clk);
        hold_start = 1'b1;
        push_random(45);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule
